// ----- rtl/cartridge_bank_mapper_irq_macros.svh -----
// assertion macros used by the mapper top level
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cbm_pkg.sv -----
// types, constants and helper functions of the cartridge bank mapper
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

   localparam int CHR_WINDOWS = 8;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   // configuration register indexes
   localparam logic [1:0] CSR_BOARD_VARIANT = 2'd0;
   localparam logic [1:0] CSR_PRG_LAST_BANK = 2'd1;
   localparam logic [1:0] CSR_CHR_LAST_BANK = 2'd2;

   // board variants
   localparam logic [2:0] VAR_A2_A1 = 3'd0;
   localparam logic [2:0] VAR_A0_A1 = 3'd1;
   localparam logic [2:0] VAR_A7_A6 = 3'd2;
   localparam logic [2:0] VAR_A2_A3 = 3'd3;
   localparam logic [2:0] VAR_A3_A2 = 3'd4;

   // address pages (A15..A12)
   localparam logic [3:0] PAGE_PRG0   = 4'h8;
   localparam logic [3:0] PAGE_MISC   = 4'h9;
   localparam logic [3:0] PAGE_PRG1   = 4'hA;
   localparam logic [3:0] PAGE_CHR_LO = 4'hB;
   localparam logic [3:0] PAGE_CHR_HI = 4'hE;
   localparam logic [3:0] PAGE_IRQ    = 4'hF;

   // register select codes within a page
   localparam logic [1:0] SEL_0 = 2'd0;
   localparam logic [1:0] SEL_1 = 2'd1;
   localparam logic [1:0] SEL_2 = 2'd2;
   localparam logic [1:0] SEL_3 = 2'd3;

   localparam logic [4:0] PRG_LAST_RESET = 5'd31;
   localparam logic [7:0] CHR_LAST_RESET = 8'd255;
   localparam logic [4:0] PRG_SLOT0_RESET = 5'd0;
   localparam logic [4:0] PRG_SLOT1_RESET = 5'd1;
   localparam logic [4:0] PRG_SLOT2_RESET = PRG_LAST_RESET - 5'd1;

   localparam logic [8:0] PRESCALE_LIMIT = 9'd338;
   localparam logic [8:0] PRESCALE_STEP  = 9'd3;
   localparam logic [7:0] COUNTER_TOP    = 8'hFF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PRG0,
      OP_PRG1,
      OP_MIRROR,
      OP_SWAP,
      OP_CHR,
      OP_RELOAD_LO,
      OP_RELOAD_HI,
      OP_IRQ_CTRL,
      OP_IRQ_ACK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] chr_slot;
      logic       chr_high;
   } dec_type;

   // control from the top to the irq unit, qualified by the transfer into the result stage
   typedef struct packed {
      logic tick;
      logic reload_lo;
      logic reload_hi;
      logic ctrl;
      logic ack;
   } irq_cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] address;
      logic [7:0]  value;
   } req_type;

   typedef struct packed {
      logic       irq_line;
      logic [1:0] mirroring;
      logic [4:0] prg_bank_0;
      logic [4:0] prg_bank_1;
      logic [4:0] prg_bank_2;
      logic [4:0] prg_bank_3;
      logic       chr_changed;
      logic [2:0] chr_slot;
      logic [7:0] chr_bank;
   } rsp_type;

   function automatic logic [4:0] clamp_prg(input logic [4:0] v, input logic [4:0] top);
      clamp_prg = (v > top) ? (v & top) : v;
   endfunction

   function automatic logic [7:0] clamp_chr(input logic [7:0] v, input logic [7:0] top);
      clamp_chr = (v > top) ? (v & top) : v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cbm_decode.sv -----
// write address decoder: page and variant select lines to a register operation
`timescale 1ns / 1ps
`default_nettype none

module cbm_decode (
   input  wire logic [15:0]     address,
   input  wire logic [2:0]      board_variant,
   output cbm_pkg::dec_type     dec
);

   logic [3:0] page;
   logic [1:0] sel;
   logic [1:0] chr_pair;

   assign page = address[15:12];

   // select lines, high bit first
   always_comb begin
      unique case (board_variant)
         cbm_pkg::VAR_A0_A1: sel = {address[0], address[1]};
         cbm_pkg::VAR_A7_A6: sel = {address[7], address[6]};
         cbm_pkg::VAR_A2_A3: sel = {address[2], address[3]};
         cbm_pkg::VAR_A3_A2: sel = {address[3], address[2]};
         default:            sel = {address[2], address[1]};
      endcase
   end

   // two character windows per page, high select picks the window
   assign chr_pair = 2'(page - cbm_pkg::PAGE_CHR_LO);

   always_comb begin
      dec.op       = cbm_pkg::OP_NONE;
      dec.chr_slot = {chr_pair, sel[1]};
      dec.chr_high = sel[0];
      priority if (page == cbm_pkg::PAGE_PRG0) begin
         dec.op = cbm_pkg::OP_PRG0;
      end else if (page == cbm_pkg::PAGE_PRG1) begin
         dec.op = cbm_pkg::OP_PRG1;
      end else if (page == cbm_pkg::PAGE_MISC) begin
         dec.op = sel[1] ? cbm_pkg::OP_SWAP : cbm_pkg::OP_MIRROR;
      end else if (page >= cbm_pkg::PAGE_CHR_LO && page <= cbm_pkg::PAGE_CHR_HI) begin
         dec.op = cbm_pkg::OP_CHR;
      end else if (page == cbm_pkg::PAGE_IRQ) begin
         unique case (sel)
            cbm_pkg::SEL_0: dec.op = cbm_pkg::OP_RELOAD_LO;
            cbm_pkg::SEL_1: dec.op = cbm_pkg::OP_RELOAD_HI;
            cbm_pkg::SEL_2: dec.op = cbm_pkg::OP_IRQ_CTRL;
            default:        dec.op = cbm_pkg::OP_IRQ_ACK;
         endcase
      end else begin
         dec.op = cbm_pkg::OP_NONE;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cbm_irq.sv -----
// irq counter with scanline prescaler, reload latch and control flags
`timescale 1ns / 1ps
`default_nettype none

module cbm_irq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cbm_pkg::irq_cmd_type cmd,
   input  wire logic [7:0]         value,
   output logic                    pending_next
);

   logic [7:0] reload_ff, reload_in;
   logic [7:0] counter_ff, counter_in;
   logic [8:0] prescale_ff, prescale_in;
   logic       enable_ff, enable_in;
   logic       cycle_mode_ff, cycle_mode_in;
   logic       ack_ff, ack_in;
   logic       pending_ff, pending_in;
   logic       clock_counter;

   always_comb begin
      reload_in     = reload_ff;
      counter_in    = counter_ff;
      prescale_in   = prescale_ff;
      enable_in     = enable_ff;
      cycle_mode_in = cycle_mode_ff;
      ack_in        = ack_ff;
      pending_in    = pending_ff;
      clock_counter = 1'b0;

      if (cmd.tick && enable_ff) begin
         if (cycle_mode_ff) begin
            clock_counter = 1'b1;
         end else if (prescale_ff < cbm_pkg::PRESCALE_LIMIT) begin
            prescale_in = prescale_ff + cbm_pkg::PRESCALE_STEP;
         end else begin
            prescale_in   = prescale_ff - cbm_pkg::PRESCALE_LIMIT;
            clock_counter = 1'b1;
         end
      end

      if (clock_counter) begin
         if (counter_ff != cbm_pkg::COUNTER_TOP) begin
            counter_in = counter_ff + 8'd1;
         end else begin
            counter_in = reload_ff;
            pending_in = 1'b1;
         end
      end

      if (cmd.reload_lo) begin
         reload_in = {reload_ff[7:4], value[3:0]};
      end
      if (cmd.reload_hi) begin
         reload_in = {value[3:0], reload_ff[3:0]};
      end
      if (cmd.ctrl) begin
         ack_in        = value[0];
         enable_in     = value[1];
         cycle_mode_in = value[2];
         pending_in    = 1'b0;
         if (value[1]) begin
            prescale_in = '0;
            counter_in  = reload_ff;
         end
      end
      if (cmd.ack) begin
         enable_in  = ack_ff;
         pending_in = 1'b0;
      end
   end

   assign pending_next = pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff     <= '0;
         counter_ff    <= '0;
         prescale_ff   <= '0;
         enable_ff     <= 1'b0;
         cycle_mode_ff <= 1'b0;
         ack_ff        <= 1'b0;
         pending_ff    <= 1'b0;
      end else begin
         reload_ff     <= reload_in;
         counter_ff    <= counter_in;
         prescale_ff   <= prescale_in;
         enable_ff     <= enable_in;
         cycle_mode_ff <= cycle_mode_in;
         ack_ff        <= ack_in;
         pending_ff    <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cartridge_bank_mapper_irq.sv -----
// top level of the cartridge bank mapper with irq counter
//
//   channel   direction   handshake              payload
//   req_*     in          req_valid/req_ready    cbm_pkg::req_type (command, address, value)
//   rsp_*     out         rsp_valid/rsp_ready    cbm_pkg::rsp_type (banks, mirroring, irq)
//   csr_*     in          csr_write_en only      csr_index, csr_wdata
//
// one item per cycle sustained while rsp_ready is high; a req transfer fills the input
// register, the item then moves into the result register and the rsp transfer follows
// the input register feeds one pass of decode and state update into the result register
// reset is synchronous and returns all bank, mirroring and irq state to power-up values
// a stalled rsp holds the result, the input register still takes one more transfer
`timescale 1ns / 1ps
`default_nettype none
`include "cartridge_bank_mapper_irq_macros.svh"

module cartridge_bank_mapper_irq (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cbm_pkg::req_type  req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cbm_pkg::rsp_type       rsp_data,
   // configuration writes
   input  wire logic              csr_write_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);

   // configuration registers
   logic [2:0] board_variant_ff;
   logic [4:0] prg_last_ff;
   logic [7:0] chr_last_ff;

   // input register
   logic              in_valid_ff;
   cbm_pkg::req_type  in_data_ff;

   // result register
   logic              rsp_valid_ff;
   cbm_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // mapper state
   logic [4:0] prg_slot_ff [3];
   logic [4:0] prg_slot_in [3];
   logic [7:0] chr_slot_ff [cbm_pkg::CHR_WINDOWS];
   logic       swap_ff, swap_in;
   logic [1:0] mirror_ff, mirror_in;

   logic                  advance;
   logic                  is_write;
   cbm_pkg::dec_type      dec;
   cbm_pkg::irq_cmd_type  irq_cmd;
   logic                  irq_pending_next;
   logic [4:0]            prg_bank;
   logic [4:0]            before_last;
   logic [7:0]            chr_cur;
   logic [7:0]            chr_new;
   logic                  chr_we;

   // item moves from the input register to the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign is_write  = (in_data_ff.command == cbm_pkg::CMD_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         board_variant_ff <= cbm_pkg::VAR_A2_A1;
         prg_last_ff      <= cbm_pkg::PRG_LAST_RESET;
         chr_last_ff      <= cbm_pkg::CHR_LAST_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            cbm_pkg::CSR_BOARD_VARIANT: board_variant_ff <= csr_wdata[2:0];
            cbm_pkg::CSR_PRG_LAST_BANK: prg_last_ff      <= csr_wdata[4:0];
            cbm_pkg::CSR_CHR_LAST_BANK: chr_last_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   cbm_decode u_decode (
      .address       (in_data_ff.address),
      .board_variant (board_variant_ff),
      .dec           (dec)
   );

   // irq unit sees only transfers that actually retire
   always_comb begin
      irq_cmd.tick      = advance && !is_write;
      irq_cmd.reload_lo = advance && is_write && (dec.op == cbm_pkg::OP_RELOAD_LO);
      irq_cmd.reload_hi = advance && is_write && (dec.op == cbm_pkg::OP_RELOAD_HI);
      irq_cmd.ctrl      = advance && is_write && (dec.op == cbm_pkg::OP_IRQ_CTRL);
      irq_cmd.ack       = advance && is_write && (dec.op == cbm_pkg::OP_IRQ_ACK);
   end

   cbm_irq u_irq (
      .clock        (clock),
      .reset        (reset),
      .cmd          (irq_cmd),
      .value        (in_data_ff.value),
      .pending_next (irq_pending_next)
   );

   // bank writes
   assign prg_bank    = cbm_pkg::clamp_prg(in_data_ff.value[4:0], prg_last_ff);
   assign before_last = prg_last_ff - 5'd1;
   assign chr_cur     = chr_slot_ff[dec.chr_slot];
   assign chr_new     = cbm_pkg::clamp_chr(
                           dec.chr_high ? {in_data_ff.value[3:0], chr_cur[3:0]}
                                        : {chr_cur[7:4], in_data_ff.value[3:0]},
                           chr_last_ff);
   assign chr_we      = advance && is_write && (dec.op == cbm_pkg::OP_CHR);

   always_comb begin
      prg_slot_in = prg_slot_ff;
      swap_in     = swap_ff;
      mirror_in   = mirror_ff;
      if (advance && is_write) begin
         unique case (dec.op)
            cbm_pkg::OP_PRG0: begin
               // swap mode moves the switchable window to the third slot
               if (swap_ff) begin
                  prg_slot_in[2] = prg_bank;
                  prg_slot_in[0] = before_last;
               end else begin
                  prg_slot_in[0] = prg_bank;
                  prg_slot_in[2] = before_last;
               end
            end
            cbm_pkg::OP_PRG1: begin
               prg_slot_in[1] = prg_bank;
            end
            cbm_pkg::OP_MIRROR: begin
               mirror_in = in_data_ff.value[1:0];
            end
            cbm_pkg::OP_SWAP: begin
               if (in_data_ff.value[1] != swap_ff) begin
                  prg_slot_in[0] = prg_slot_ff[2];
                  prg_slot_in[2] = prg_slot_ff[0];
                  swap_in        = in_data_ff.value[1];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_slot_ff[0] <= cbm_pkg::PRG_SLOT0_RESET;
         prg_slot_ff[1] <= cbm_pkg::PRG_SLOT1_RESET;
         prg_slot_ff[2] <= cbm_pkg::PRG_SLOT2_RESET;
         swap_ff        <= 1'b0;
         mirror_ff      <= 2'd0;
      end else begin
         prg_slot_ff <= prg_slot_in;
         swap_ff     <= swap_in;
         mirror_ff   <= mirror_in;
      end
   end

   // character windows reset to the identity mapping
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbm_pkg::CHR_WINDOWS; i++) begin
            chr_slot_ff[i] <= 8'(i);
         end
      end else if (chr_we) begin
         chr_slot_ff[dec.chr_slot] <= chr_new;
      end
   end

   // result is the state after the item
   always_comb begin
      rsp_data_in.irq_line    = irq_pending_next;
      rsp_data_in.mirroring   = mirror_in;
      rsp_data_in.prg_bank_0  = prg_slot_in[0];
      rsp_data_in.prg_bank_1  = prg_slot_in[1];
      rsp_data_in.prg_bank_2  = prg_slot_in[2];
      rsp_data_in.prg_bank_3  = prg_last_ff;
      rsp_data_in.chr_changed = chr_we;
      rsp_data_in.chr_slot    = chr_we ? dec.chr_slot : 3'd0;
      rsp_data_in.chr_bank    = chr_we ? chr_new : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= advance || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `CBM_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff, "retired item left no result")
   `CBM_ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_data_ff), "held item lost or changed")
   `CBM_ASSERT_NOW(a_chr_fields_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.chr_changed, rsp_data_ff.chr_slot == 3'd0 && rsp_data_ff.chr_bank == 8'd0, "chr fields set without a chr write")
   `CBM_ASSERT_NOW(a_empty_input_ready, clock, reset, !in_valid_ff, req_ready, "input register empty but not ready")

endmodule

`default_nettype wire

// ----- bench/tb_cartridge_bank_mapper_irq.sv -----
// self-checking testbench for the cartridge bank mapper with irq counter
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper_irq;
   import cbm_pkg::*;

   // idle cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASE_ITEMS = 90;
   localparam int SQUEEZE_CYCLES = 150;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic       csr_write_en = 1'b0;
   logic [1:0] csr_index = CSR_BOARD_VARIANT;
   logic [7:0] csr_wdata = 8'h00;

   cartridge_bank_mapper_irq dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow copy of the mapper: configuration and state
   // ---------------------------------------------------------------
   logic [2:0] cfg_variant;
   logic [4:0] prg_last;
   logic [7:0] chr_last;
   logic [4:0] prg_window [3];
   logic [7:0] chr_window [CHR_WINDOWS];
   logic       prg_swapped;
   logic [1:0] mirror_sel;
   logic [7:0] shadow_reload;
   logic [7:0] shadow_counter;
   logic [8:0] prescaler;
   logic       irq_en, irq_cycle, irq_ack, irq_flag;

   rsp_type bank_view_q [$];

   int errors = 0;
   int checked = 0;
   int sent = 0;
   int irq_fires = 0;
   int settings = 0;
   int long_stalls = 0;
   int quiet = 0;

   // sender and receiver pacing
   bit calm = 1'b0;
   bit squeeze = 1'b0;
   int hold_left = 0;
   int pace_roll = 0;

   task automatic shadow_reset();
      cfg_variant = VAR_A2_A1;
      prg_last    = 5'd31;
      chr_last    = 8'd255;
      prg_window[0] = 5'd0;
      prg_window[1] = 5'd1;
      prg_window[2] = 5'd30;
      for (int i = 0; i < CHR_WINDOWS; i++) chr_window[i] = 8'(i);
      prg_swapped = 1'b0;
      mirror_sel  = 2'd0;
      shadow_reload  = 8'h00;
      shadow_counter = 8'h00;
      prescaler   = 9'd0;
      irq_en      = 1'b0;
      irq_cycle   = 1'b0;
      irq_ack     = 1'b0;
      irq_flag    = 1'b0;
   endtask

   // register select lines per board variant, high select first
   function automatic logic [1:0] select_of(input logic [15:0] a);
      case (cfg_variant)
         VAR_A0_A1: select_of = {a[0], a[1]};
         VAR_A7_A6: select_of = a[7:6];
         VAR_A2_A3: select_of = {a[2], a[3]};
         VAR_A3_A2: select_of = a[3:2];
         default:   select_of = a[2:1];  // unused variants decode like the first
      endcase
   endfunction

   // random address on a page whose select lines give the wanted register
   function automatic logic [15:0] addr_for(input logic [3:0] page, input logic [1:0] sel);
      logic [15:0] a;
      a = 16'($urandom);
      a[15:12] = page;
      case (cfg_variant)
         VAR_A0_A1: begin
            a[0] = sel[1];
            a[1] = sel[0];
         end
         VAR_A7_A6: a[7:6] = sel;
         VAR_A2_A3: begin
            a[2] = sel[1];
            a[3] = sel[0];
         end
         VAR_A3_A2: a[3:2] = sel;
         default:   a[2:1] = sel;
      endcase
      return a;
   endfunction

   // applies one item to the shadow and returns the mapper view after it
   function automatic rsp_type advance_mapper(input req_type r);
      rsp_type    o;
      logic [3:0] page;
      logic [1:0] sel;
      logic [4:0] pb;
      logic [4:0] tmp;
      logic [2:0] win;
      logic [7:0] nb;
      o = '0;
      if (r.command == CMD_TICK) begin
         if (irq_en) begin
            // scanline mode: 341/3 prescaler gates the counter clock
            if (!irq_cycle && prescaler < PRESCALE_LIMIT) begin
               prescaler = prescaler + PRESCALE_STEP;
            end else begin
               if (!irq_cycle) prescaler = prescaler - PRESCALE_LIMIT;
               if (shadow_counter != COUNTER_TOP) begin
                  shadow_counter = shadow_counter + 8'd1;
               end else begin
                  shadow_counter = shadow_reload;
                  irq_flag  = 1'b1;
                  irq_fires++;
               end
            end
         end
      end else begin
         page = r.address[15:12];
         sel  = select_of(r.address);
         pb   = (r.value[4:0] > prg_last) ? (r.value[4:0] & prg_last) : r.value[4:0];
         if (page == PAGE_PRG0) begin
            // second-to-last bank wraps when the rom is a single bank
            prg_window[prg_swapped ? 2 : 0] = pb;
            prg_window[prg_swapped ? 0 : 2] = prg_last - 5'd1;
         end else if (page == PAGE_PRG1) begin
            prg_window[1] = pb;
         end else if (page == PAGE_MISC) begin
            if (sel == SEL_0 || sel == SEL_1) begin
               mirror_sel = r.value[1:0];
            end else if (r.value[1] != prg_swapped) begin
               tmp = prg_window[0];
               prg_window[0] = prg_window[2];
               prg_window[2] = tmp;
               prg_swapped = r.value[1];
            end
         end else if (page >= PAGE_CHR_LO && page <= PAGE_CHR_HI) begin
            win = 3'((page - PAGE_CHR_LO) * 2) + 3'(sel[1]);
            nb  = chr_window[win];
            if (sel[0]) nb[7:4] = r.value[3:0];
            else nb[3:0] = r.value[3:0];
            if (nb > chr_last) nb = nb & chr_last;
            chr_window[win] = nb;
            o.chr_changed = 1'b1;
            o.chr_slot    = win;
            o.chr_bank    = nb;
         end else if (page == PAGE_IRQ) begin
            case (sel)
               SEL_0: shadow_reload[3:0] = r.value[3:0];
               SEL_1: shadow_reload[7:4] = r.value[3:0];
               SEL_2: begin
                  irq_ack   = r.value[0];
                  irq_en    = r.value[1];
                  irq_cycle = r.value[2];
                  if (irq_en) begin
                     prescaler = 9'd0;
                     shadow_counter = shadow_reload;
                  end
                  irq_flag = 1'b0;
               end
               default: begin
                  irq_en   = irq_ack;
                  irq_flag = 1'b0;
               end
            endcase
         end
         // pages below the cartridge window fall through untouched
      end
      o.irq_line   = irq_flag;
      o.mirroring  = mirror_sel;
      o.prg_bank_0 = prg_window[0];
      o.prg_bank_1 = prg_window[1];
      o.prg_bank_2 = prg_window[2];
      o.prg_bank_3 = prg_last;
      return o;
   endfunction

   // hand-written mapper view for the directed rows
   function automatic rsp_type view_of(input logic irq, input logic [1:0] mir,
                                       input logic [4:0] p0, input logic [4:0] p1,
                                       input logic [4:0] p2, input logic [4:0] p3,
                                       input logic cc, input logic [2:0] cs,
                                       input logic [7:0] cb);
      rsp_type o;
      o.irq_line    = irq;
      o.mirroring   = mir;
      o.prg_bank_0  = p0;
      o.prg_bank_1  = p1;
      o.prg_bank_2  = p2;
      o.prg_bank_3  = p3;
      o.chr_changed = cc;
      o.chr_slot    = cs;
      o.chr_bank    = cb;
      return o;
   endfunction

   task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
      errors++;
      if (errors <= 40)
         $display("mismatch at result %0d: %s got %0h want %0h", checked, field, got, want);
   endtask

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one item, wait for its transfer, then queue its expected view
   task automatic send(input req_type item, input bit typed, input rsp_type typed_view);
      int      gap;
      rsp_type v;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      v = advance_mapper(item);
      bank_view_q.push_back(typed ? typed_view : v);
      sent++;
   endtask

   task automatic send_tick();
      req_type r;
      r.command = CMD_TICK;
      r.address = 16'($urandom);
      r.value   = 8'($urandom);
      send(r, 1'b0, '0);
   endtask

   task automatic send_write(input logic [15:0] a, input logic [7:0] d);
      req_type r;
      r.command = CMD_WRITE;
      r.address = a;
      r.value   = d;
      send(r, 1'b0, '0);
   endtask

   // a well-formed irq program: reload, enable, then a run of ticks mixed with acknowledges and noise
   task automatic irq_run();
      bit cyc;
      int n;
      logic [3:0] hi, lo;
      calm = ($urandom_range(3) == 0);
      cyc  = ($urandom_range(99) < 70);
      hi   = cyc ? 4'($urandom_range(8, 15)) : 4'hF;
      lo   = cyc ? 4'($urandom) : 4'($urandom_range(14, 15));
      n    = cyc ? $urandom_range(10, 150) : $urandom_range(120, 260);
      send_write(addr_for(PAGE_IRQ, SEL_0), {4'($urandom), lo});
      send_write(addr_for(PAGE_IRQ, SEL_1), {4'($urandom), hi});
      send_write(addr_for(PAGE_IRQ, SEL_2), {5'($urandom), cyc, 1'b1, 1'($urandom)});
      repeat (n) begin
         case ($urandom_range(99))
            0, 1, 2, 3: send_write(addr_for(PAGE_IRQ, SEL_3), 8'($urandom));
            4, 5:       noise_item();
            default:    send_tick();
         endcase
      end
   endtask

   // unstructured traffic: ticks, writes to random mapper registers and stray addresses
   task automatic noise_item();
      int r;
      req_type q;
      r = $urandom_range(99);
      if (r < 45) begin
         send_tick();
      end else if (r < 60) begin
         q.command = ($urandom_range(1) != 0) ? CMD_TICK : CMD_WRITE;
         q.address = 16'($urandom);
         q.value   = 8'($urandom);
         send(q, 1'b0, '0);
      end else begin
         send_write(addr_for(4'($urandom_range(8, 15)), 2'($urandom)), 8'($urandom));
      end
   endtask

   // drop valid, let the pipe drain and then keep the clock running idle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bank_view_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_BOARD_VARIANT: cfg_variant = data[2:0];
         CSR_PRG_LAST_BANK: prg_last    = data[4:0];
         default:           chr_last    = data;
      endcase
   endtask

   // unused upper bits of the write data carry noise
   task automatic set_board(input logic [2:0] bv, input logic [4:0] pl, input logic [7:0] cl);
      drain();
      csr_put(CSR_BOARD_VARIANT, {5'($urandom), bv});
      csr_put(CSR_PRG_LAST_BANK, {3'($urandom), pl});
      csr_put(CSR_CHR_LAST_BANK, cl);
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings++;
   endtask

   // ---------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type view;
   } plan_row;

   plan_row plan [$];

   task automatic add_row(input cmd_type c, input logic [15:0] a, input logic [7:0] d,
                          input bit typed, input rsp_type v);
      plan_row p;
      p.item.command = c;
      p.item.address = a;
      p.item.value   = d;
      p.typed = typed;
      p.view  = v;
      plan.push_back(p);
   endtask

   // main sequence
   initial begin
      int start;
      shadow_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-up view, then the write decode at board variant 0
      add_row(CMD_TICK,  16'hFFFF, 8'hFF, 1'b1, view_of(1'b0, 2'd0, 5'd0, 5'd1, 5'd30,
                                                        5'd31, 1'b0, 3'd0, 8'd0));
      // writes below the cartridge window are ignored
      add_row(CMD_WRITE, 16'h7FFF, 8'hFF, 1'b1, view_of(1'b0, 2'd0, 5'd0, 5'd1, 5'd30,
                                                        5'd31, 1'b0, 3'd0, 8'd0));
      add_row(CMD_WRITE, 16'h8000, 8'hFF, 1'b1, view_of(1'b0, 2'd0, 5'd31, 5'd1, 5'd30,
                                                        5'd31, 1'b0, 3'd0, 8'd0));
      add_row(CMD_WRITE, 16'hA000, 8'h00, 1'b1, view_of(1'b0, 2'd0, 5'd31, 5'd0, 5'd30,
                                                        5'd31, 1'b0, 3'd0, 8'd0));
      add_row(CMD_WRITE, 16'h9000, 8'h03, 1'b1, view_of(1'b0, 2'd3, 5'd31, 5'd0, 5'd30,
                                                        5'd31, 1'b0, 3'd0, 8'd0));
      add_row(CMD_WRITE, 16'h9004, 8'h02, 1'b0, '0);   // swap on
      add_row(CMD_WRITE, 16'h8000, 8'h05, 1'b0, '0);   // lands in the swapped slot
      add_row(CMD_WRITE, 16'h9006, 8'h00, 1'b0, '0);   // swap off
      add_row(CMD_WRITE, 16'h9002, 8'h01, 1'b0, '0);   // mirroring through the other select
      add_row(CMD_WRITE, 16'hB000, 8'hFF, 1'b0, '0);
      add_row(CMD_WRITE, 16'hB002, 8'hFF, 1'b1, view_of(1'b0, 2'd1, 5'd5, 5'd0, 5'd30,
                                                        5'd31, 1'b1, 3'd0, 8'd255));
      add_row(CMD_WRITE, 16'hE006, 8'hA5, 1'b0, '0);
      add_row(CMD_WRITE, 16'hC004, 8'h0C, 1'b0, '0);
      add_row(CMD_WRITE, 16'hD002, 8'h0F, 1'b0, '0);
      add_row(CMD_WRITE, 16'hF000, 8'h0E, 1'b0, '0);   // reload low nibble
      add_row(CMD_WRITE, 16'hF002, 8'h0F, 1'b0, '0);   // reload high nibble
      add_row(CMD_WRITE, 16'hF004, 8'h07, 1'b0, '0);   // enable, cycle mode, ack
      add_row(CMD_TICK,  16'h0000, 8'h00, 1'b0, '0);
      add_row(CMD_TICK,  16'h0000, 8'h00, 1'b0, '0);   // counter passes the top
      add_row(CMD_WRITE, 16'hF006, 8'h00, 1'b0, '0);   // acknowledge keeps it enabled
      add_row(CMD_TICK,  16'h1234, 8'h55, 1'b0, '0);
      add_row(CMD_WRITE, 16'hF004, 8'h02, 1'b0, '0);   // scanline mode
      add_row(CMD_TICK,  16'h0000, 8'h00, 1'b0, '0);
      add_row(CMD_WRITE, 16'hF006, 8'h00, 1'b0, '0);   // acknowledge now disables
      add_row(CMD_TICK,  16'h0000, 8'h00, 1'b0, '0);
      add_row(CMD_WRITE, 16'h0000, 8'h00, 1'b0, '0);

      foreach (plan[i]) send(plan[i].item, plan[i].typed, plan[i].view);

      // random phases, each under its own board setting
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_board(VAR_A0_A1, 5'd15, 8'd127);
            1: set_board(VAR_A7_A6, 5'd1, 8'd0);
            2: set_board(VAR_A2_A3, 5'd31, 8'd255);
            3: set_board(VAR_A3_A2, 5'd0, 8'd1);      // single-bank program rom
            4: set_board(3'd7, 5'($urandom_range(1, 31)), 8'($urandom));
            default: set_board(VAR_A2_A1, 5'($urandom_range(1, 31)), 8'($urandom));
         endcase
         start = sent;
         if (ph == 0 || ph == 3) begin
            // long receiver hold-off against a sender that never pauses
            calm = 1'b1;
            squeeze = 1'b1;
            repeat (40) noise_item();
         end
         while (sent - start < PHASE_ITEMS) begin
            if ($urandom_range(99) < 35) irq_run();
            else noise_item();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("checked %0d results from %0d transfers under %0d board settings",
               checked, sent, settings + 1);
      $display("irq overflows %0d, long receiver stalls %0d, mismatches %0d",
               irq_fires, long_stalls, errors);
      if (errors == 0) begin
         $display("cartridge_bank_mapper_irq verification clean");
      end else begin
         $display("cartridge_bank_mapper_irq verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (squeeze) begin
         squeeze = 1'b0;
         long_stalls++;
         hold_left = SQUEEZE_CYCLES;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         pace_roll = $urandom_range(99);
         if (pace_roll < 70) begin
            rsp_ready <= 1'b1;
         end else if (pace_roll < 95) begin
            rsp_ready <= 1'b0;
            hold_left = $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b0;
            hold_left = $urandom_range(10, 40);
         end
      end
   end

   rsp_type head;

   // compare every result transfer with the oldest expected view
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (bank_view_q.size() == 0) begin
            report("result with nothing expected", rsp_data.chr_bank, 8'h00);
         end else begin
            head = bank_view_q.pop_front();
            checked++;
            if (rsp_data.irq_line !== head.irq_line)
               report("irq_line", 8'(rsp_data.irq_line), 8'(head.irq_line));
            if (rsp_data.mirroring !== head.mirroring)
               report("mirroring", 8'(rsp_data.mirroring), 8'(head.mirroring));
            if (rsp_data.prg_bank_0 !== head.prg_bank_0)
               report("prg_bank_0", 8'(rsp_data.prg_bank_0), 8'(head.prg_bank_0));
            if (rsp_data.prg_bank_1 !== head.prg_bank_1)
               report("prg_bank_1", 8'(rsp_data.prg_bank_1), 8'(head.prg_bank_1));
            if (rsp_data.prg_bank_2 !== head.prg_bank_2)
               report("prg_bank_2", 8'(rsp_data.prg_bank_2), 8'(head.prg_bank_2));
            if (rsp_data.prg_bank_3 !== head.prg_bank_3)
               report("prg_bank_3", 8'(rsp_data.prg_bank_3), 8'(head.prg_bank_3));
            if (rsp_data.chr_changed !== head.chr_changed)
               report("chr_changed", 8'(rsp_data.chr_changed), 8'(head.chr_changed));
            if (rsp_data.chr_slot !== head.chr_slot)
               report("chr_slot", 8'(rsp_data.chr_slot), 8'(head.chr_slot));
            if (rsp_data.chr_bank !== head.chr_bank)
               report("chr_bank", rsp_data.chr_bank, head.chr_bank);
         end
      end
   end

   // watchdog: too long without a transfer on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     quiet, bank_view_q.size());
            $display("cartridge_bank_mapper_irq verification failed");
            $finish;
         end
      end
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_decode.sv
rtl/cbm_irq.sv
rtl/cartridge_bank_mapper_irq.sv
bench/tb_cartridge_bank_mapper_irq.sv
